### hw/rtl/rhsi_pkg.sv
// Shared constants for the RGB to HSI pixel converter.
package rhsi_pkg;

    localparam int unsigned CORDIC_STEPS = 17;
    localparam int unsigned HUE_W = 16;
    localparam int unsigned SAT_W = 16;
    localparam int unsigned INT_W = 16;
    localparam int unsigned ANGLE_W = 18;
    localparam int unsigned FRAC_SHIFT = 24;

    localparam logic [24:0] SQRT3_Q24 = 25'd29058991;
    localparam logic [ANGLE_W-1:0] HALF_PI_Q16 = 18'd102944;
    localparam logic [ANGLE_W-1:0] PI_Q16 = 18'd205887;
    localparam logic [HUE_W-1:0] TWO_PI_Q13 = 16'd51472;
    localparam logic [SAT_W-1:0] SAT_ONE = 16'd32768;

    localparam logic [16:0] ATAN_TAB [CORDIC_STEPS] = '{
        17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047,
        17'd1024, 17'd512, 17'd256, 17'd128, 17'd64, 17'd32, 17'd16,
        17'd8, 17'd4, 17'd2, 17'd1
    };

endpackage

### hw/rtl/rgb_to_hsi_pixel_top.sv
// Top level of the RGB to HSI pixel converter: a fully pipelined datapath.
//
// The input channel takes one RGB word (s_red, s_green, s_blue) per clock
// when s_valid and s_ready are both high. The result channel gives one word
// (m_hue, m_saturation, m_intensity) per input word, in order, under
// m_valid and m_ready. There are 21 register stages, the last of which
// drives the result word. A new word can enter in every cycle unless a
// stalled receiver has filled every stage, so the throughput is one pixel
// per clock. The depth is set by the 17 CORDIC steps that give the hue, with
// the 16-step saturation divider and the intensity reciprocal multiply
// running alongside them. Each stage has its own valid bit and advances
// whenever the stage after it is empty or moving, so a stalled receiver
// holds the output word while empty stages ahead of it still fill, and
// s_ready falls only when every stage holds a word. A synchronous reset
// clears all valid bits; the datapath registers are not reset.
module rgb_to_hsi_pixel_top #(
    parameter int unsigned COLOR_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_red,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_blue,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_hue,
    output logic [15:0] m_saturation,
    output logic [15:0] m_intensity
);

    localparam int unsigned CB = COLOR_BITS;
    localparam int unsigned SUM_W = CB + 2;
    localparam int unsigned DEN_W = CB + 3;
    localparam int unsigned REM_W = CB + 4;
    localparam int unsigned NUM_W = SUM_W + 16;
    localparam int unsigned K_W = 16;
    localparam int unsigned PROD_W = NUM_W + K_W;
    localparam int unsigned XW = CB + 28;
    localparam int unsigned ZW = rhsi_pkg::ANGLE_W + 1;
    localparam int unsigned NST = 21;
    localparam int unsigned DIV_FIRST = 2;
    localparam int unsigned ROT_FIRST = 3;
    localparam longint unsigned MAXV = (64'd1 << CB) - 64'd1;
    localparam longint unsigned INT_D = 64'd6 * MAXV;
    localparam longint unsigned INT_K = (64'd1 << NUM_W) / INT_D;

    typedef struct packed {
        logic                    zero_sum;
        logic                    base_zero;
        logic                    b_lt_g;
        logic [SUM_W-1:0]        sum;
        logic [DEN_W-1:0]        den;
        logic [REM_W-1:0]        rem;
        logic [15:0]             q;
        logic signed [CB+1:0]    xd;
        logic [CB-1:0]           ad;
        logic [NUM_W-1:0]        num;
        logic [PROD_W-1:0]       iprod;
        logic [15:0]             iq;
        logic signed [XW-1:0]    x;
        logic signed [XW-1:0]    y;
        logic signed [ZW-1:0]    z;
        logic [15:0]             hue;
        logic [15:0]             sat;
        logic [15:0]             inten;
    } stage_t;

    stage_t         stg_reg [NST];
    stage_t         stg_next [NST];
    logic [NST-1:0] valid_reg;
    logic [NST-1:0] en;

    always_comb begin
        en[NST-1] = !valid_reg[NST-1] || m_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign s_ready = en[0];
    assign m_valid = valid_reg[NST-1];
    assign m_hue = stg_reg[NST-1].hue;
    assign m_saturation = stg_reg[NST-1].sat;
    assign m_intensity = stg_reg[NST-1].inten;

    always_comb begin
        logic [CB-1:0]    r;
        logic [CB-1:0]    g;
        logic [CB-1:0]    b;
        logic [CB-1:0]    mn;
        logic [SUM_W-1:0] sum;
        r = CB'(s_red);
        g = CB'(s_green);
        b = CB'(s_blue);
        mn = r;
        if (g < mn) begin
            mn = g;
        end
        if (b < mn) begin
            mn = b;
        end
        sum = SUM_W'(r) + SUM_W'(g) + SUM_W'(b);
        stg_next[0] = '0;
        stg_next[0].zero_sum = (sum == '0);
        stg_next[0].base_zero = (mn == '0) || ((r == g) && (g == b));
        stg_next[0].b_lt_g = (b < g);
        stg_next[0].sum = sum;
        stg_next[0].den = {sum, 1'b0};
        stg_next[0].rem = REM_W'(sum - SUM_W'({mn, 1'b0}) - SUM_W'(mn));
        stg_next[0].xd = $signed({1'b0, r, 1'b0}) - $signed({2'b00, g})
                         - $signed({2'b00, b});
        stg_next[0].ad = (g > b) ? (g - b) : (b - g);
        stg_next[0].num = {sum, 16'd0} + NUM_W'(3 * MAXV);
    end

    for (genvar k = 1; k < NST; k++) begin : g_stage
        localparam int unsigned QB = (k >= DIV_FIRST && k < DIV_FIRST + 16)
                                     ? 15 - (k - DIV_FIRST) : 0;
        localparam int unsigned RI =
            (k >= ROT_FIRST && k < ROT_FIRST + rhsi_pkg::CORDIC_STEPS)
            ? k - ROT_FIRST : 0;

        always_comb begin
            stage_t                p;
            logic signed [XW-1:0]  xo;
            logic signed [XW-1:0]  yo;
            logic [15:0]           lowb;
            logic [REM_W-1:0]      shifted;
            logic [NUM_W-1:0]      diff;
            logic signed [ZW-1:0]  zc;
            logic [rhsi_pkg::ANGLE_W-1:0] za;
            logic [15:0]           base;
            p = stg_reg[k-1];
            xo = p.x;
            yo = p.y;
            lowb = 16'(p.sum);
            shifted = '0;
            diff = '0;
            zc = '0;
            za = '0;
            base = '0;
            if (k == 1) begin
                p.x = {{(XW-CB-2){p.xd[CB+1]}}, p.xd} << rhsi_pkg::FRAC_SHIFT;
                p.y = XW'({{(XW-CB){1'b0}}, p.ad} * XW'(rhsi_pkg::SQRT3_Q24));
                p.iprod = PROD_W'({{K_W{1'b0}}, p.num} * PROD_W'(INT_K));
            end
            if (k == 2) begin
                if (xo[XW-1]) begin
                    p.x = yo;
                    p.y = -xo;
                    p.z = ZW'(rhsi_pkg::HALF_PI_Q16);
                end else begin
                    p.z = '0;
                end
                p.iq = p.iprod[PROD_W-1:NUM_W];
            end
            if (k == 3) begin
                p.iprod = PROD_W'({{(PROD_W-16){1'b0}}, p.iq} * PROD_W'(INT_D));
            end
            if (k == 4) begin
                diff = p.num - p.iprod[NUM_W-1:0];
                if (diff >= NUM_W'(INT_D)) begin
                    p.iq = p.iq + 16'd1;
                end
                p.inten = p.iq;
            end
            if (k >= DIV_FIRST && k < DIV_FIRST + 16) begin
                shifted = {p.rem[REM_W-2:0], lowb[QB]};
                if (shifted >= REM_W'(p.den)) begin
                    p.rem = shifted - REM_W'(p.den);
                    p.q[QB] = 1'b1;
                end else begin
                    p.rem = shifted;
                end
            end
            if (k >= ROT_FIRST && k < ROT_FIRST + rhsi_pkg::CORDIC_STEPS) begin
                if (!yo[XW-1]) begin
                    p.x = xo + (yo >>> RI);
                    p.y = yo - (xo >>> RI);
                    p.z = p.z + ZW'(rhsi_pkg::ATAN_TAB[RI]);
                end else begin
                    p.x = xo - (yo >>> RI);
                    p.y = yo + (xo >>> RI);
                    p.z = p.z - ZW'(rhsi_pkg::ATAN_TAB[RI]);
                end
            end
            if (k == NST - 1) begin
                zc = p.z;
                if (zc < 0) begin
                    za = '0;
                end else if (zc > $signed(ZW'(rhsi_pkg::PI_Q16))) begin
                    za = rhsi_pkg::PI_Q16;
                end else begin
                    za = zc[rhsi_pkg::ANGLE_W-1:0];
                end
                za = za + rhsi_pkg::ANGLE_W'(4);
                base = 16'(za >> 3);
                if (p.base_zero) begin
                    base = '0;
                end
                p.hue = p.b_lt_g ? (rhsi_pkg::TWO_PI_Q13 - base) : base;
                p.sat = p.zero_sum ? rhsi_pkg::SAT_ONE : p.q;
            end
            stg_next[k] = p;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NST; k++) begin
            if (en[k]) begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

endmodule

### hw/rtl/rhsi_checker.sv
// Port checker for the RGB to HSI pixel converter, bound to its top level.
module rhsi_checker #(
    parameter int unsigned DEPTH = 21
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_red,
    input logic [7:0]  s_green,
    input logic [7:0]  s_blue,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_hue,
    input logic [15:0] m_saturation,
    input logic [15:0] m_intensity
);

    logic [5:0] cnt_reg;
    logic [5:0] cnt_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (in_acc && !out_acc) begin
            cnt_next = cnt_reg + 6'd1;
        end else if (out_acc && !in_acc) begin
            cnt_next = cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hue)
            && $stable(m_saturation) && $stable(m_intensity))
        else $error("Result word changed while stalled.");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 6'(DEPTH))
        else $error("More words in flight than pipeline stages.");

    a_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> cnt_reg != 6'd0)
        else $error("Result word without an accepted input word.");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_hue <= rhsi_pkg::TWO_PI_Q13
            && m_saturation <= rhsi_pkg::SAT_ONE
            && m_intensity <= rhsi_pkg::SAT_ONE)
        else $error("Result word out of range.");

endmodule

bind rgb_to_hsi_pixel_top rhsi_checker #(.DEPTH(21)) u_rhsi_checker (.*);
